// ===== rtl/ssa_pkg.sv =====
`default_nettype none

package ssa_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int SHARE_DEPTH_DEF = 3;

  localparam int MODE_W   = 2;
  localparam int OWNER_W  = 12;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_SHARE   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_FAIL    = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_REFUSED   = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE   = 2'd0,
    KIND_EVICT  = 2'd1,
    KIND_RESUME = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACQ_T,
    ST_ACQ_H,
    ST_REL,
    ST_EVICT,
    ST_EMIT,
    ST_PUSH,
    ST_PUSH_A,
    ST_PUSH_B
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   granted;
    logic                nc;
    logic [OWNER_W-1:0]  other;
    kind_t               kind;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/ssa_link_mem.sv =====
`default_nettype none

module ssa_link_mem #(
  parameter int SLOTS = ssa_pkg::SLOTS_DEF,
  parameter int SW    = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [SW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [SW-1:0] wr_addr,
  input  wire logic [SW-1:0] wr_data,
  output logic      [SW-1:0] rd_data
);
  import ssa_pkg::*;

  logic [SW-1:0] mem [SLOTS];
  logic          written_r [SLOTS];
  logic [SW-1:0] rd_q_r;
  logic [SW-1:0] rd_addr_r;
  logic          rd_wr_r;
  logic [SW-1:0] dflt;

  // unwritten link reads as its reset value: i+1, last slot wraps to 0
  assign dflt    = (rd_addr_r == SW'(SLOTS - 1)) ? '0 : rd_addr_r + SW'(1);
  assign rd_data = rd_wr_r ? rd_q_r : dflt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        written_r[i] <= 1'b0;
      end
      rd_wr_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_wr_r <= written_r[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ssa_queue_mem.sv =====
`default_nettype none

module ssa_queue_mem #(
  parameter int SLOTS       = ssa_pkg::SLOTS_DEF,
  parameter int SHARE_DEPTH = ssa_pkg::SHARE_DEPTH_DEF,
  parameter int SW          = 4
) (
  input  wire logic                                            clk,
  input  wire logic                                            rd_en,
  input  wire logic [SW-1:0]                                   rd_addr,
  input  wire logic                                            wr_en,
  input  wire logic [SW-1:0]                                   wr_addr,
  input  wire logic [SHARE_DEPTH-1:0][ssa_pkg::OWNER_W-1:0]    wr_data,
  output logic      [SHARE_DEPTH-1:0][ssa_pkg::OWNER_W-1:0]    rd_data
);
  import ssa_pkg::*;

  // one row per slot; entries past the slot's owner count are don't-care
  logic [SHARE_DEPTH-1:0][OWNER_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/shared_slot_allocator_unit.sv =====
`default_nettype none

// Shared slot allocator. Keeps SLOTS slots on a circular free list (tail
// register plus one next link per slot, head = link of tail) and a queue of
// up to SHARE_DEPTH owners per slot. Modes: acquire pops the head slot and
// queues the owner; share puts a healthy slot with queue room back at the
// head; release dequeues the owner and either names the next owner to resume
// or frees the slot (a failed slot evicts every other owner, one result item
// each, last set on the final one); mark-failed flags a slot. One item is in
// work at a time and in_ready is low until it is done. All link traffic goes
// through one link memory with separate read and write ports and registered
// read, and all queue traffic through one row memory. Acquire reads the link
// of tail, then the link of head plus the queue row, then updates and emits;
// a free-list push reads the link of tail, then links the slot to the old
// head and the tail to the slot; a failed-slot release emits at least one
// result item before its push. Each result waits in the output register
// until out_ready; the sequencer stalls while it is occupied.
module shared_slot_allocator_unit #(
  parameter int SLOTS       = ssa_pkg::SLOTS_DEF,
  parameter int SHARE_DEPTH = ssa_pkg::SHARE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [ssa_pkg::MODE_W-1:0]      in_mode,
  input  wire logic [ssa_pkg::OWNER_W-1:0]     in_owner_id,
  input  wire logic [ssa_pkg::SLOT_W-1:0]      in_slot,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ssa_pkg::STATUS_W-1:0]         out_status,
  output logic [ssa_pkg::SLOT_W-1:0]           out_granted_slot,
  output logic                                 out_needs_connect,
  output logic [ssa_pkg::OWNER_W-1:0]          out_other_owner,
  output logic [ssa_pkg::KIND_W-1:0]           out_owner_kind,
  output logic                                 out_last
);
  import ssa_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;      // slot index bits
  localparam int CW = $clog2(SHARE_DEPTH + 1);              // owner count bits
  localparam int DW = $clog2(SHARE_DEPTH);                  // queue position bits

  typedef logic [SHARE_DEPTH-1:0][OWNER_W-1:0] row_t;

  // sequencer and working registers
  state_t            state_r, state_nxt;
  logic [OWNER_W-1:0] owner_r, owner_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [SW-1:0]     h_r, h_nxt;               // popped head slot
  logic [SW-1:0]     tail_r, tail_nxt;
  logic              tail_vld_r, tail_vld_nxt;
  res_t              res_r, res_nxt;            // pending single result
  logic              push_pend_r, push_pend_nxt;
  row_t              row_r, row_nxt;            // queue row under eviction
  logic [SHARE_DEPTH-1:0] mask_r, mask_nxt;     // owners still to evict

  // per-slot state
  logic [CW-1:0]     cnt_r    [SLOTS];
  logic              failed_r [SLOTS];
  logic              onlist_r [SLOTS];

  logic              cnt_we, failed_we, onl_we;
  logic [SW-1:0]     cnt_idx, failed_idx, onl_idx;
  logic [CW-1:0]     cnt_wd;
  logic              failed_wd, onl_wd;

  // output register
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r, out_nxt;
  logic              out_load;
  logic              out_free;

  // memory ports
  logic              lk_rd_en, lk_wr_en;
  logic [SW-1:0]     lk_rd_addr, lk_wr_addr, lk_wr_data, lk_rd_data;
  logic              q_rd_en, q_wr_en;
  logic [SW-1:0]     q_rd_addr, q_wr_addr;
  row_t              q_wr_data, q_rd_data;

  // input decode
  logic [SW-1:0]     in_idx;
  logic              in_slot_ok;

  // queue helpers
  logic [CW-1:0]     cnt_s, cnt_h, cnt_new;
  row_t              row_ins, row_up, row_shift;
  logic              found;
  logic [SHARE_DEPTH-1:0] ev_mask, ev_onehot, mask_left;
  logic [DW-1:0]     ev_sel;

  assign in_idx     = SW'(in_slot);
  assign in_slot_ok = (32'(in_slot) < SLOTS);
  assign in_ready   = (state_r == ST_IDLE);
  assign out_free   = !out_valid_r || out_ready;

  ssa_link_mem #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (lk_rd_en),
    .rd_addr (lk_rd_addr),
    .wr_en   (lk_wr_en),
    .wr_addr (lk_wr_addr),
    .wr_data (lk_wr_data),
    .rd_data (lk_rd_data)
  );

  ssa_queue_mem #(
    .SLOTS       (SLOTS),
    .SHARE_DEPTH (SHARE_DEPTH),
    .SW          (SW)
  ) u_queue (
    .clk     (clk),
    .rd_en   (q_rd_en),
    .rd_addr (q_rd_addr),
    .wr_en   (q_wr_en),
    .wr_addr (q_wr_addr),
    .wr_data (q_wr_data),
    .rd_data (q_rd_data)
  );

  // --- queue row arithmetic ---
  assign cnt_s  = cnt_r[slot_r];
  assign cnt_h  = cnt_r[h_r];
  assign row_up = row_t'(q_rd_data >> OWNER_W);   // entry k takes entry k+1

  // acquire: append owner at the current count
  always_comb begin
    row_ins = q_rd_data;
    for (int k = 0; k < SHARE_DEPTH; k++) begin
      if (CW'(k) == cnt_h) begin
        row_ins[k] = owner_r;
      end
    end
  end

  // release on a healthy slot: drop the first matching owner, close the gap
  always_comb begin
    found     = 1'b0;
    row_shift = q_rd_data;
    for (int k = 0; k < SHARE_DEPTH; k++) begin
      if (!found && (CW'(k) < cnt_s) && (q_rd_data[k] == owner_r)) begin
        found = 1'b1;
      end
      if (found) begin
        row_shift[k] = row_up[k];
      end
    end
  end

  assign cnt_new = found ? cnt_s - CW'(1) : cnt_s;

  // release on a failed slot: every queued owner except the releasing one
  always_comb begin
    for (int k = 0; k < SHARE_DEPTH; k++) begin
      ev_mask[k] = (CW'(k) < cnt_s) && (q_rd_data[k] != owner_r);
    end
  end

  // lowest pending evictee
  assign ev_onehot = mask_r & (~mask_r + SHARE_DEPTH'(1));
  assign mask_left = mask_r & ~ev_onehot;

  always_comb begin
    ev_sel = '0;
    for (int k = SHARE_DEPTH - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        ev_sel = DW'(k);
      end
    end
  end

  // --- next state ---
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (in_mode == MODE_ACQUIRE) begin
            state_nxt = tail_vld_r ? ST_ACQ_T : ST_EMIT;
          end else if (!in_slot_ok) begin
            state_nxt = ST_EMIT;
          end else if (in_mode == MODE_RELEASE) begin
            state_nxt = ST_REL;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_ACQ_T:  state_nxt = ST_ACQ_H;
      ST_ACQ_H:  state_nxt = ST_EMIT;
      ST_REL:    state_nxt = failed_r[slot_r] ? ST_EVICT : ST_EMIT;
      ST_EVICT: begin
        if (out_free && ((mask_r == '0) || (mask_left == '0))) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = push_pend_r ? ST_PUSH : ST_IDLE;
        end
      end
      ST_PUSH: begin
        if (onlist_r[slot_r] || !tail_vld_r) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_PUSH_A;
        end
      end
      ST_PUSH_A: state_nxt = ST_PUSH_B;
      ST_PUSH_B: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // --- datapath and memory control ---
  always_comb begin
    owner_nxt     = owner_r;
    slot_nxt      = slot_r;
    h_nxt         = h_r;
    tail_nxt      = tail_r;
    tail_vld_nxt  = tail_vld_r;
    res_nxt       = res_r;
    push_pend_nxt = push_pend_r;
    row_nxt       = row_r;
    mask_nxt      = mask_r;

    lk_rd_en   = 1'b0;
    lk_rd_addr = tail_r;
    lk_wr_en   = 1'b0;
    lk_wr_addr = tail_r;
    lk_wr_data = slot_r;
    q_rd_en    = 1'b0;
    q_rd_addr  = slot_r;
    q_wr_en    = 1'b0;
    q_wr_addr  = slot_r;
    q_wr_data  = row_ins;

    cnt_we     = 1'b0;
    cnt_idx    = slot_r;
    cnt_wd     = '0;
    failed_we  = 1'b0;
    failed_idx = slot_r;
    failed_wd  = 1'b0;
    onl_we     = 1'b0;
    onl_idx    = slot_r;
    onl_wd     = 1'b0;

    out_load = 1'b0;
    out_nxt  = res_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          owner_nxt     = in_owner_id;
          slot_nxt      = in_idx;
          push_pend_nxt = 1'b0;
          res_nxt       = '{status: STAT_OK, granted: '0, nc: 1'b0, other: '0,
                            kind: KIND_NONE, last: 1'b1};
          priority if (in_mode == MODE_ACQUIRE) begin
            if (tail_vld_r) begin
              lk_rd_en   = 1'b1;
              lk_rd_addr = tail_r;
            end else begin
              res_nxt.status = STAT_REFUSED;
            end
          end else if (!in_slot_ok) begin
            res_nxt.status = STAT_REFUSED;
          end else if (in_mode == MODE_SHARE) begin
            if (!failed_r[in_idx] && (cnt_r[in_idx] < CW'(SHARE_DEPTH - 1))) begin
              push_pend_nxt = 1'b1;
            end else begin
              res_nxt.status = STAT_REFUSED;
            end
          end else if (in_mode == MODE_FAIL) begin
            failed_we  = 1'b1;
            failed_idx = in_idx;
            failed_wd  = 1'b1;
          end else begin
            q_rd_en   = 1'b1;
            q_rd_addr = in_idx;
          end
        end
      end

      ST_ACQ_T: begin
        // link of tail is the head slot
        h_nxt      = lk_rd_data;
        lk_rd_en   = 1'b1;
        lk_rd_addr = lk_rd_data;
        q_rd_en    = 1'b1;
        q_rd_addr  = lk_rd_data;
      end

      ST_ACQ_H: begin
        if (h_r == tail_r) begin
          tail_vld_nxt = 1'b0;            // last free slot taken
        end else begin
          lk_wr_en   = 1'b1;
          lk_wr_addr = tail_r;
          lk_wr_data = lk_rd_data;        // tail skips over the head
        end
        onl_we  = 1'b1;
        onl_idx = h_r;
        onl_wd  = 1'b0;
        if (cnt_h < CW'(SHARE_DEPTH)) begin
          q_wr_en   = 1'b1;
          q_wr_addr = h_r;
          q_wr_data = row_ins;
          cnt_we    = 1'b1;
          cnt_idx   = h_r;
          cnt_wd    = cnt_h + CW'(1);
        end
        failed_we      = 1'b1;
        failed_idx     = h_r;
        failed_wd      = 1'b0;
        res_nxt.granted = SLOT_W'(h_r);
        res_nxt.nc      = failed_r[h_r];
      end

      ST_REL: begin
        if (failed_r[slot_r]) begin
          row_nxt       = q_rd_data;
          mask_nxt      = ev_mask;
          cnt_we        = 1'b1;
          cnt_wd        = '0;
          push_pend_nxt = 1'b1;
        end else begin
          if (found) begin
            q_wr_en   = 1'b1;
            q_wr_data = row_shift;
            cnt_we    = 1'b1;
            cnt_wd    = cnt_new;
          end
          res_nxt.status = found ? STAT_OK : STAT_NOT_FOUND;
          if (cnt_new != '0) begin
            res_nxt.other = row_shift[0];
            res_nxt.kind  = KIND_RESUME;
          end else begin
            push_pend_nxt = 1'b1;
          end
        end
      end

      ST_EVICT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt  = '{status: STAT_OK, granted: '0, nc: 1'b0, other: '0,
                       kind: KIND_NONE, last: 1'b1};
          if (mask_r != '0) begin
            out_nxt.other = row_r[ev_sel];
            out_nxt.kind  = KIND_EVICT;
            out_nxt.last  = (mask_left == '0);
            mask_nxt      = mask_left;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt  = res_r;
        end
      end

      ST_PUSH: begin
        if (!onlist_r[slot_r]) begin
          if (!tail_vld_r) begin
            tail_nxt     = slot_r;
            tail_vld_nxt = 1'b1;
            lk_wr_en     = 1'b1;
            lk_wr_addr   = slot_r;
            lk_wr_data   = slot_r;        // single-entry ring
            onl_we       = 1'b1;
            onl_wd       = 1'b1;
          end else begin
            lk_rd_en   = 1'b1;
            lk_rd_addr = tail_r;
          end
        end
      end

      ST_PUSH_A: begin
        lk_wr_en   = 1'b1;
        lk_wr_addr = slot_r;
        lk_wr_data = lk_rd_data;          // new head points at old head
      end

      ST_PUSH_B: begin
        lk_wr_en   = 1'b1;
        lk_wr_addr = tail_r;
        lk_wr_data = slot_r;
        onl_we     = 1'b1;
        onl_wd     = 1'b1;
      end

      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // --- registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tail_r      <= SW'(SLOTS - 1);
      tail_vld_r  <= 1'b1;
      push_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_r      <= tail_nxt;
      tail_vld_r  <= tail_vld_nxt;
      push_pend_r <= push_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    owner_r <= owner_nxt;
    slot_r  <= slot_nxt;
    h_r     <= h_nxt;
    res_r   <= res_nxt;
    row_r   <= row_nxt;
    mask_r  <= mask_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        cnt_r[i]    <= '0;
        failed_r[i] <= 1'b1;              // not connected after reset
        onlist_r[i] <= 1'b1;              // every slot starts free
      end
    end else begin
      if (cnt_we) begin
        cnt_r[cnt_idx] <= cnt_wd;
      end
      if (failed_we) begin
        failed_r[failed_idx] <= failed_wd;
      end
      if (onl_we) begin
        onlist_r[onl_idx] <= onl_wd;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_granted_slot  = out_r.granted;
  assign out_needs_connect = out_r.nc;
  assign out_other_owner   = out_r.other;
  assign out_owner_kind    = out_r.kind;
  assign out_last          = out_r.last;

endmodule

`default_nettype wire

// ===== rtl/ssa_checker.sv =====
`default_nettype none

module ssa_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [ssa_pkg::STATUS_W-1:0]    out_status,
  input wire logic [ssa_pkg::SLOT_W-1:0]      out_granted_slot,
  input wire logic                            out_needs_connect,
  input wire logic [ssa_pkg::OWNER_W-1:0]     out_other_owner,
  input wire logic [ssa_pkg::KIND_W-1:0]      out_owner_kind,
  input wire logic                            out_last
);
  import ssa_pkg::*;

  // one item at a time: after an accept the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_other_owner)
      && $stable(out_owner_kind) && $stable(out_last) && $stable(out_status))
    else $error("stalled result changed");

  // only evictions come in multi-item bursts
  a_burst_is_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_owner_kind == KIND_EVICT)
    else $error("non-final result that is not an eviction");

  // evictions carry no grant and report ok
  a_evict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_owner_kind == KIND_EVICT |->
      out_status == STAT_OK && out_granted_slot == '0 && !out_needs_connect)
    else $error("eviction result with stray fields");

  // reconnect flag only on a successful grant
  a_nc_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_needs_connect |->
      out_status == STAT_OK && out_owner_kind == KIND_NONE && out_other_owner == '0)
    else $error("needs_connect outside a grant");

endmodule

bind shared_slot_allocator_unit ssa_checker u_ssa_checker (.*);

`default_nettype wire
